// ----- hw/rtl/edd_pkg.sv -----
package edd_pkg;

   // Field widths of one transaction on each channel.
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int YDIFF_W  = 15;
   localparam int MDIFF_W  = 5;
   localparam int DDIFF_W  = 6;
   localparam int DAYS_W   = 23;

   // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
   // Exact for every 14-bit dividend.
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

   localparam logic [DAYS_W-1:0] DAYS_PER_YEAR  = 23'd365;
   // Year zero is a leap year placed directly before year one.
   localparam logic [DAYS_W-1:0] YEAR_ZERO_BASE = DAYS_W'(-366);

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [MDIFF_W-1:0] MONTHS_PER_YEAR = 5'd12;

   // Load enables of the three pipeline stages inside the submodules.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // Out-of-range month codes are folded onto January or December.
   function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] r;
      if (m < MONTH_JAN) begin
         r = MONTH_JAN;
      end else if (m > MONTH_DEC) begin
         r = MONTH_DEC;
      end else begin
         r = m;
      end
      return r;
   endfunction

   // Length of a month in a common year.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:                      r = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
         default:                   r = 5'd31;
      endcase
      return r;
   endfunction

   // Days in the months before month m of a common year.
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hw/rtl/edd_req_if.sv -----
interface edd_req_if;
   import edd_pkg::*;

   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  start_year;
   logic [MONTH_W-1:0] start_month;
   logic [DAY_W-1:0]   start_day;
   logic [YEAR_W-1:0]  now_year;
   logic [MONTH_W-1:0] now_month;
   logic [DAY_W-1:0]   now_day;

   modport source (
      output valid, start_year, start_month, start_day, now_year, now_month, now_day,
      input  ready
   );

   modport sink (
      input  valid, start_year, start_month, start_day, now_year, now_month, now_day,
      output ready
   );
endinterface

// ----- hw/rtl/edd_rsp_if.sv -----
interface edd_rsp_if;
   import edd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [YDIFF_W-1:0] years_elapsed;
   logic [MONTH_W-1:0]        months_elapsed;
   logic signed [DDIFF_W-1:0] days_elapsed;
   logic signed [DAYS_W-1:0]  total_days;

   modport source (
      output valid, years_elapsed, months_elapsed, days_elapsed, total_days,
      input  ready
   );

   modport sink (
      input  valid, years_elapsed, months_elapsed, days_elapsed, total_days,
      output ready
   );
endinterface

// ----- hw/rtl/edd_daynum.sv -----
// Three-stage day number of one date, 1 January of year 1 being day 1.
// The count is kept modulo 2^23.
module edd_daynum (
   input  logic                          clock,
   input  edd_pkg::stage_en_type         en,
   input  logic [edd_pkg::YEAR_W-1:0]    year,
   input  logic [edd_pkg::MONTH_W-1:0]   month,
   input  logic [edd_pkg::DAY_W-1:0]     day,
   output logic                          leap_s2,
   output logic [edd_pkg::DAYS_W-1:0]    day_num
);
   import edd_pkg::*;

   // Stage 1 registers.
   logic [YEAR_W-1:0]  y1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [DAY_W-1:0]   d1_ff;
   logic               zero1_ff;
   logic [PROD_W-1:0]  py1_ff, py1_in;
   logic [PROD_W-1:0]  pn1_ff, pn1_in;

   // Stage 2 registers.
   logic [MONTH_W-1:0] m2_ff;
   logic [DAY_W-1:0]   d2_ff;
   logic               leap2_ff, leap2_in;
   logic [DAYS_W-1:0]  by2_ff, by2_in;

   // Stage 3 register.
   logic [DAYS_W-1:0]  dn3_ff, dn3_in;

   logic [QUOT_W-1:0]  qy;
   logic [QUOT_W-1:0]  qn;
   logic [YEAR_W:0]    hund;
   logic               cent;
   logic [YEAR_W-1:0]  n;

   // Stage 1: reciprocal products for the year and for the year before it.
   always_comb begin
      py1_in = PROD_W'(year) * PROD_W'(RECIP_100);
      pn1_in = PROD_W'(YEAR_W'(year - 1'b1)) * PROD_W'(RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         y1_ff    <= year;
         m1_ff    <= month;
         d1_ff    <= day;
         zero1_ff <= (year == '0);
         py1_ff   <= py1_in;
         pn1_ff   <= pn1_in;
      end
   end

   // Stage 2: leap year test and the days of all whole years before it.
   always_comb begin
      qy   = py1_ff[PROD_W-1:RECIP_SHIFT];
      qn   = pn1_ff[PROD_W-1:RECIP_SHIFT];
      hund = ((YEAR_W+1)'(qy) << 6) + ((YEAR_W+1)'(qy) << 5) + ((YEAR_W+1)'(qy) << 2);
      cent = ({1'b0, y1_ff} == hund);
      leap2_in = (y1_ff[1:0] == 2'b00) && (!cent || (qy[1:0] == 2'b00));
      n = y1_ff - 1'b1;
      if (zero1_ff) begin
         by2_in = YEAR_ZERO_BASE;
      end else begin
         by2_in = DAYS_W'(n) * DAYS_PER_YEAR + DAYS_W'(n >> 2)
                - DAYS_W'(qn) + DAYS_W'(qn >> 2);
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         m2_ff    <= m1_ff;
         d2_ff    <= d1_ff;
         leap2_ff <= leap2_in;
         by2_ff   <= by2_in;
      end
   end

   // Stage 3: add the months before the given one, the leap day and the day.
   always_comb begin
      dn3_in = by2_ff + DAYS_W'(days_before(m2_ff))
             + DAYS_W'((m2_ff > MONTH_FEB) && leap2_ff) + DAYS_W'(d2_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         dn3_ff <= dn3_in;
      end
   end

   assign leap_s2 = leap2_ff;
   assign day_num = dn3_ff;

endmodule

// ----- hw/rtl/edd_brkdn.sv -----
// Three-stage breakdown into years, months and days with month and year
// borrows. The leap flag of the start year arrives from its stage-2 register.
module edd_brkdn (
   input  logic                          clock,
   input  edd_pkg::stage_en_type         en,
   input  logic [edd_pkg::YEAR_W-1:0]    start_year,
   input  logic [edd_pkg::MONTH_W-1:0]   start_month,
   input  logic [edd_pkg::DAY_W-1:0]     start_day,
   input  logic [edd_pkg::YEAR_W-1:0]    now_year,
   input  logic [edd_pkg::MONTH_W-1:0]   now_month,
   input  logic [edd_pkg::DAY_W-1:0]     now_day,
   input  logic                          start_leap_s2,
   output logic [edd_pkg::YDIFF_W-1:0]   years,
   output logic [edd_pkg::MONTH_W-1:0]   months,
   output logic [edd_pkg::DDIFF_W-1:0]   days
);
   import edd_pkg::*;

   logic [YDIFF_W-1:0] yd1_ff, yd1_in;
   logic [MDIFF_W-1:0] md1_ff, md1_in;
   logic [DDIFF_W-1:0] dd1_ff, dd1_in;
   logic [MONTH_W-1:0] sm1_ff;

   logic [YDIFF_W-1:0] yd2_ff;
   logic [MDIFF_W-1:0] md2_ff, md2_in;
   logic [DDIFF_W-1:0] dd2_ff, dd2_in;
   logic               feb2_ff, feb2_in;

   logic [YDIFF_W-1:0] yd3_ff, yd3_in;
   logic [MONTH_W-1:0] md3_ff, md3_in;
   logic [DDIFF_W-1:0] dd3_ff, dd3_in;

   logic               borrow;
   logic [MONTH_W-1:0] prev_month;

   // Stage 1: field by field differences.
   always_comb begin
      yd1_in = {1'b0, now_year} - {1'b0, start_year};
      md1_in = {1'b0, now_month} - {1'b0, start_month};
      dd1_in = {1'b0, now_day} - {1'b0, start_day};
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         yd1_ff <= yd1_in;
         md1_ff <= md1_in;
         dd1_ff <= dd1_in;
         sm1_ff <= start_month;
      end
   end

   // Stage 2: a negative day difference borrows the month before the start.
   always_comb begin
      borrow     = dd1_ff[DDIFF_W-1];
      prev_month = (sm1_ff == MONTH_JAN) ? MONTH_DEC : sm1_ff - 1'b1;
      md2_in     = md1_ff - MDIFF_W'(borrow);
      dd2_in     = borrow ? dd1_ff + DDIFF_W'(month_len(prev_month)) : dd1_ff;
      feb2_in    = borrow && (sm1_ff == MONTH_MAR);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         yd2_ff  <= yd1_ff;
         md2_ff  <= md2_in;
         dd2_ff  <= dd2_in;
         feb2_ff <= feb2_in;
      end
   end

   // Stage 3: leap day of a borrowed February and the year borrow.
   always_comb begin
      dd3_in = dd2_ff + DDIFF_W'(feb2_ff && start_leap_s2);
      if (md2_ff[MDIFF_W-1]) begin
         yd3_in = yd2_ff - 1'b1;
         md3_in = MONTH_W'(md2_ff + MONTHS_PER_YEAR);
      end else begin
         yd3_in = yd2_ff;
         md3_in = md2_ff[MONTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         yd3_ff <= yd3_in;
         md3_ff <= md3_in;
         dd3_ff <= dd3_in;
      end
   end

   assign years  = yd3_ff;
   assign months = md3_ff;
   assign days   = dd3_ff;

endmodule

// ----- hw/rtl/elapsed_date_difference.sv -----
// Channel   Modport  Transaction
// req_link  sink     start and current date (year, month, day)
// rsp_link  source   years, months, days elapsed and signed total day count
//
// Four register stages: products, whole-year count, day numbers, then the
// subtraction into the output register. A transaction moves through them in
// that order before rsp_link.valid shows it; one transaction can enter every
// cycle unless the output stalls. Each stage holds while the one after it is
// full and stalled; req_link.ready falls only when all four stages hold data
// and rsp_link.ready is low. Synchronous reset clears the valid bits only.
module elapsed_date_difference (
   input  logic       clock,
   input  logic       reset,
   edd_req_if.sink    req_link,
   edd_rsp_if.source  rsp_link
);
   import edd_pkg::*;

   logic [MONTH_W-1:0] start_month_c;
   logic [MONTH_W-1:0] now_month_c;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   stage_en_type en;

   logic               start_leap_s2;
   logic               now_leap_s2;
   logic [DAYS_W-1:0]  start_dn;
   logic [DAYS_W-1:0]  now_dn;
   logic [YDIFF_W-1:0] years_s3;
   logic [MONTH_W-1:0] months_s3;
   logic [DDIFF_W-1:0] days_s3;

   logic [YDIFF_W-1:0] years_ff;
   logic [MONTH_W-1:0] months_ff;
   logic [DDIFF_W-1:0] days_ff;
   logic [DAYS_W-1:0]  total_ff, total_in;

   // Month codes are folded once and shared by both datapaths.
   assign start_month_c = clamp_month(req_link.start_month);
   assign now_month_c   = clamp_month(req_link.now_month);

   // A stage loads when it is empty or its contents move on this cycle.
   always_comb begin
      rdy4  = !v4_ff || rsp_link.ready;
      rdy3  = !v3_ff || rdy4;
      rdy2  = !v2_ff || rdy3;
      rdy1  = !v1_ff || rdy2;
      en.s1 = rdy1;
      en.s2 = rdy2;
      en.s3 = rdy3;
   end

   assign req_link.ready = rdy1;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_link.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   edd_daynum u_start_dn (
      .clock   (clock),
      .en      (en),
      .year    (req_link.start_year),
      .month   (start_month_c),
      .day     (req_link.start_day),
      .leap_s2 (start_leap_s2),
      .day_num (start_dn)
   );

   edd_daynum u_now_dn (
      .clock   (clock),
      .en      (en),
      .year    (req_link.now_year),
      .month   (now_month_c),
      .day     (req_link.now_day),
      .leap_s2 (now_leap_s2),
      .day_num (now_dn)
   );

   edd_brkdn u_brkdn (
      .clock         (clock),
      .en            (en),
      .start_year    (req_link.start_year),
      .start_month   (start_month_c),
      .start_day     (req_link.start_day),
      .now_year      (req_link.now_year),
      .now_month     (now_month_c),
      .now_day       (req_link.now_day),
      .start_leap_s2 (start_leap_s2),
      .years         (years_s3),
      .months        (months_s3),
      .days          (days_s3)
   );

   // Output stage: signed day count, wrapped to its field width. The leap
   // flag of the current year is folded into its own day number already.
   assign total_in = now_dn - start_dn + DAYS_W'(now_leap_s2 & 1'b0);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         years_ff  <= years_s3;
         months_ff <= months_s3;
         days_ff   <= days_s3;
         total_ff  <= total_in;
      end
   end

   assign rsp_link.valid          = v4_ff;
   assign rsp_link.years_elapsed  = years_ff;
   assign rsp_link.months_elapsed = months_ff;
   assign rsp_link.days_elapsed   = days_ff;
   assign rsp_link.total_days     = total_ff;

endmodule
